// ===== src/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and codes for the keyed slot table: operation and status
// codes, configuration reset value, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package kst_pkg;

   localparam int MAX_SLOTS_DEFAULT = 64;

   localparam int ACTION_W    = 2;
   localparam int KEY_W       = 31;
   localparam int INDEX_W     = 6;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 7;

   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 7'd64;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd4;
   localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd5;

   typedef struct packed {
      logic capture;
      logic scan;
      logic commit;
      logic q_read;
      logic q_resolve;
      logic load_out;
   } kst_cmd_type;

   typedef struct packed {
      logic hit;
      logic exhausted;
   } kst_stat_type;

endpackage

// ===== src/kst_req_if.sv =====
// ----------------------------------------------------------------------------
// kst_req_if
// Request channel: one word carries an action, a key and a slot index.
// ----------------------------------------------------------------------------
interface kst_req_if
   import kst_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [KEY_W-1:0]    key_value;
   logic [INDEX_W-1:0]  slot_index;

   modport source (output valid, action, key_value, slot_index, input ready);
   modport sink   (input valid, action, key_value, slot_index, output ready);
endinterface

// ===== src/kst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// kst_rsp_if
// Response channel: one word carries status, slot, key and table counts.
// ----------------------------------------------------------------------------
interface kst_rsp_if
   import kst_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  slot_result;
   logic [KEY_W-1:0]    key_result;
   logic [COUNT_W-1:0]  free_slots;
   logic [COUNT_W-1:0]  used_slots;

   modport source (output valid, status, slot_result, key_result, free_slots,
                   used_slots, input ready);
   modport sink   (input valid, status, slot_result, key_result, free_slots,
                   used_slots, output ready);
endinterface

// ===== src/kst_ram.sv =====
// ----------------------------------------------------------------------------
// kst_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module kst_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/kst_ctrl.sv =====
// ----------------------------------------------------------------------------
// kst_ctrl
// Sequencer for the slot table: accepts a word, runs the scan or the
// query read, and hands the result to the output register.
// ----------------------------------------------------------------------------
module kst_ctrl
   import kst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  kst_stat_type        stat,
   output kst_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_QREAD = 3'd2;
   localparam logic [2:0] ST_QRES  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_action inside {ACT_INSERT, ACT_REMOVE}) begin
                  state_in = ST_SCAN;
               end else if (req_action == ACT_QUERY) begin
                  state_in = ST_QREAD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit || stat.exhausted) begin
               cmd.commit = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_QREAD: begin
            cmd.q_read = 1'b1;
            state_in   = ST_QRES;
         end
         ST_QRES: begin
            cmd.q_resolve = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/kst_datapath.sv =====
// ----------------------------------------------------------------------------
// kst_datapath
// Slot table storage and scan pipeline: key RAM, occupancy bits, count,
// scan counter with one compare stage, result and output registers.
// ----------------------------------------------------------------------------
module kst_datapath
   import kst_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [COUNT_W-1:0]  csr_write_data,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [KEY_W-1:0]    req_key_value,
   input  logic [INDEX_W-1:0]  req_slot_index,
   input  kst_cmd_type         cmd,
   output kst_stat_type        stat,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [INDEX_W-1:0]  rsp_slot_result,
   output logic [KEY_W-1:0]    rsp_key_result,
   output logic [COUNT_W-1:0]  rsp_free_slots,
   output logic [COUNT_W-1:0]  rsp_used_slots
);

   localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
   localparam int TABLE_DEPTH = (MAX_SLOTS < COUNT_MAX) ? MAX_SLOTS : COUNT_MAX;
   localparam int TW          = $clog2(TABLE_DEPTH);
   localparam int CW          = $clog2(TABLE_DEPTH + 1);

   logic [COUNT_W-1:0]     slot_count_ff, slot_count_in;
   logic [TABLE_DEPTH-1:0] full_ff, full_in;
   logic [COUNT_W-1:0]     occ_ff, occ_in;
   logic [ACTION_W-1:0]    op_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [INDEX_W-1:0]     qidx_ff;
   logic [CW-1:0]          scan_ff, scan_in;
   logic                   pipe_v_ff, pipe_v_in;
   logic [TW-1:0]          cmp_idx_ff;
   logic                   cmp_full_ff;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [INDEX_W-1:0]     res_slot_ff, res_slot_in;
   logic [KEY_W-1:0]       res_key_ff, res_key_in;
   logic [STATUS_W-1:0]    out_status_ff;
   logic [INDEX_W-1:0]     out_slot_ff;
   logic [KEY_W-1:0]       out_key_ff;
   logic [COUNT_W-1:0]     out_free_ff, out_used_ff;

   logic [COUNT_W-1:0]     live_n;
   logic                   issue;
   logic                   key_eq;
   logic                   ram_we;
   logic [TW-1:0]          ram_rd_addr;
   logic [KEY_W-1:0]       ram_rd_data;
   logic                   q_in_range;
   logic                   q_full;

   assign live_n = (32'(slot_count_ff) > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH)
                                                      : slot_count_ff;
   assign issue  = (COUNT_W'(scan_ff) < live_n);
   assign key_eq = (ram_rd_data == key_ff);

   always_comb begin
      stat.hit = 1'b0;
      if (pipe_v_ff) begin
         if (op_ff == ACT_INSERT) begin
            stat.hit = !cmp_full_ff || key_eq;
         end else begin
            stat.hit = cmp_full_ff && key_eq;
         end
      end
      stat.exhausted = !issue && (!pipe_v_ff || !stat.hit);
   end

   assign ram_rd_addr = cmd.q_read ? TW'(qidx_ff) : scan_ff[TW-1:0];
   assign ram_we      = cmd.commit && stat.hit && (op_ff == ACT_INSERT) && !cmp_full_ff;

   kst_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cmp_idx_ff),
      .wr_data (key_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign q_in_range = ({1'b0, qidx_ff} < live_n);
   assign q_full     = q_in_range && full_ff[TW'(qidx_ff)];

   always_comb begin
      slot_count_in = slot_count_ff;
      full_in       = full_ff;
      occ_in        = occ_ff;
      scan_in       = scan_ff;
      pipe_v_in     = 1'b0;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_key_in    = res_key_ff;

      if (cmd.capture) begin
         scan_in       = '0;
         res_status_in = STS_RANGE;
         res_slot_in   = '0;
         res_key_in    = '0;
      end

      if (cmd.scan && issue) begin
         scan_in   = scan_ff + CW'(1);
         pipe_v_in = 1'b1;
      end

      if (cmd.commit) begin
         if (stat.hit) begin
            res_slot_in = INDEX_W'(cmp_idx_ff);
            if (op_ff == ACT_INSERT) begin
               if (cmp_full_ff) begin
                  res_status_in = STS_DUPLICATE;
               end else begin
                  res_status_in       = STS_OK;
                  full_in[cmp_idx_ff] = 1'b1;
                  occ_in              = occ_ff + COUNT_W'(1);
               end
            end else begin
               res_status_in       = STS_OK;
               full_in[cmp_idx_ff] = 1'b0;
               if (occ_ff != '0) begin
                  occ_in = occ_ff - COUNT_W'(1);
               end
            end
         end else begin
            res_slot_in   = '0;
            res_status_in = (op_ff == ACT_INSERT) ? STS_FULL : STS_NOT_FOUND;
         end
      end

      if (cmd.q_resolve) begin
         res_slot_in = qidx_ff;
         if (!q_in_range) begin
            res_status_in = STS_RANGE;
         end else if (!q_full) begin
            res_status_in = STS_EMPTY;
         end else begin
            res_status_in = STS_OK;
            res_key_in    = ram_rd_data;
         end
      end

      if (csr_write_enable) begin
         slot_count_in = csr_write_data;
         full_in       = '0;
         occ_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RESET;
         full_ff       <= '0;
         occ_ff        <= '0;
         pipe_v_ff     <= 1'b0;
      end else begin
         slot_count_ff <= slot_count_in;
         full_ff       <= full_in;
         occ_ff        <= occ_in;
         pipe_v_ff     <= pipe_v_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_key_ff    <= res_key_in;
      if (cmd.capture) begin
         op_ff   <= req_action;
         key_ff  <= req_key_value;
         qidx_ff <= req_slot_index;
      end
      if (cmd.scan && issue) begin
         cmp_idx_ff  <= scan_ff[TW-1:0];
         cmp_full_ff <= full_ff[scan_ff[TW-1:0]];
      end
      if (cmd.load_out) begin
         out_status_ff <= res_status_ff;
         out_slot_ff   <= res_slot_ff;
         out_key_ff    <= res_key_ff;
         out_free_ff   <= live_n - occ_ff;
         out_used_ff   <= occ_ff;
      end
   end

   assign rsp_status      = out_status_ff;
   assign rsp_slot_result = out_slot_ff;
   assign rsp_key_result  = out_key_ff;
   assign rsp_free_slots  = out_free_ff;
   assign rsp_used_slots  = out_used_ff;

   a_occ_matches_bits: assert property (@(posedge clock) disable iff (reset)
      32'($countones(full_ff)) == 32'(occ_ff))
      else $error("occupied count differs from occupancy bits");

   a_occ_within_live: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= live_n)
      else $error("occupied count exceeds live slot count");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (ram_we && !csr_write_enable) |=> (occ_ff == $past(occ_ff) + COUNT_W'(1)))
      else $error("insert into empty slot did not advance count");

endmodule

// ===== src/keyed_slot_table_core.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_table_core
// First-fit slot table with insert, remove and query of 31-bit keys.
// ----------------------------------------------------------------------------
// One word is in work at a time. Insert and remove scan the live slots
// from slot 0 through the key RAM read port, one slot per cycle, and stop
// at the first hit or when the scan is exhausted. A query reads the key
// RAM once and then resolves the read; an unknown action goes straight
// to the output stage. The output register holds a finished word while the
// next request is taken. Writing slot_count empties the table: the
// occupancy bits and count clear in the cycle after the write.
module keyed_slot_table_core
   import kst_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data,
   kst_req_if.sink            req_chan,
   kst_rsp_if.source          rsp_chan
);

   kst_cmd_type  cmd;
   kst_stat_type stat;

   kst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   kst_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_action       (req_chan.action),
      .req_key_value    (req_chan.key_value),
      .req_slot_index   (req_chan.slot_index),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_chan.status),
      .rsp_slot_result  (rsp_chan.slot_result),
      .rsp_key_result   (rsp_chan.key_result),
      .rsp_free_slots   (rsp_chan.free_slots),
      .rsp_used_slots   (rsp_chan.used_slots)
   );

endmodule

// ===== tb/kst_table_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_table_scoreboard
// Watches the request, response and csr ports of the keyed slot table. It
// keeps its own copy of the slot table and the slot count, predicts the
// response word of every accepted request, and compares each accepted
// response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module kst_table_scoreboard
   import kst_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data,
   kst_req_if                 req_mon,
   kst_rsp_if                 rsp_mon,
   output int                 fail_count,
   output int                 due_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  slot;
      logic [KEY_W-1:0]    key;
      logic [COUNT_W-1:0]  free_n;
      logic [COUNT_W-1:0]  used_n;
   } table_answer_type;

   logic [KEY_W-1:0]   slot_key   [MAX_SLOTS_DEFAULT];
   bit                 slot_taken [MAX_SLOTS_DEFAULT];
   int                 taken_total;
   logic [COUNT_W-1:0] slot_limit;
   table_answer_type   answers_due [$];

   initial begin
      fail_count = 0;
      due_count  = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic restart_table(input logic [COUNT_W-1:0] limit);
      slot_limit = limit;
      taken_total = 0;
      for (int i = 0; i < MAX_SLOTS_DEFAULT; i++) begin
         slot_taken[i] = 1'b0;
         slot_key[i]   = '0;
      end
   endtask

   function automatic table_answer_type predict_answer(input logic [ACTION_W-1:0] act,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [INDEX_W-1:0] idx);
      table_answer_type ans;
      int               live;
      bit               done;
      live = (slot_limit > MAX_SLOTS_DEFAULT) ? MAX_SLOTS_DEFAULT : int'(slot_limit);
      ans = '0;
      ans.status = STS_RANGE;
      done = 1'b0;
      case (act)
         ACT_INSERT: begin
            ans.status = STS_FULL;
            for (int i = 0; i < live; i++) begin
               if (!done && slot_taken[i] && slot_key[i] == key) begin
                  ans.status = STS_DUPLICATE;
                  ans.slot = INDEX_W'(i);
                  done = 1'b1;
               end else if (!done && !slot_taken[i]) begin
                  slot_taken[i] = 1'b1;
                  slot_key[i] = key;
                  taken_total++;
                  ans.status = STS_OK;
                  ans.slot = INDEX_W'(i);
                  done = 1'b1;
               end
            end
         end
         ACT_REMOVE: begin
            ans.status = STS_NOT_FOUND;
            for (int i = 0; i < live; i++) begin
               if (!done && slot_taken[i] && slot_key[i] == key) begin
                  slot_taken[i] = 1'b0;
                  if (taken_total > 0) taken_total--;
                  ans.status = STS_OK;
                  ans.slot = INDEX_W'(i);
                  done = 1'b1;
               end
            end
         end
         ACT_QUERY: begin
            ans.slot = idx;
            if (idx >= live) begin
               ans.status = STS_RANGE;
            end else if (!slot_taken[idx]) begin
               ans.status = STS_EMPTY;
            end else begin
               ans.status = STS_OK;
               ans.key = slot_key[idx];
            end
         end
         default: ;
      endcase
      ans.free_n = COUNT_W'(live - taken_total);
      ans.used_n = COUNT_W'(taken_total);
      return ans;
   endfunction

   always @(posedge clock) begin
      table_answer_type got;
      table_answer_type want;
      if (reset) begin
         restart_table(SLOT_COUNT_RESET);
         answers_due.delete();
      end else begin
         if (csr_write_enable) restart_table(csr_write_data);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status = rsp_mon.status;
            got.slot   = rsp_mon.slot_result;
            got.key    = rsp_mon.key_result;
            got.free_n = rsp_mon.free_slots;
            got.used_n = rsp_mon.used_slots;
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("response word with none due, status %0d",
                                         got.status));
            end else begin
               want = answers_due.pop_front();
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
               if (got.slot !== want.slot)
                  report_mismatch($sformatf("slot_result %0d, want %0d", got.slot, want.slot));
               if (got.key !== want.key)
                  report_mismatch($sformatf("key_result %h, want %h", got.key, want.key));
               if (got.free_n !== want.free_n)
                  report_mismatch($sformatf("free_slots %0d, want %0d",
                                            got.free_n, want.free_n));
               if (got.used_n !== want.used_n)
                  report_mismatch($sformatf("used_slots %0d, want %0d",
                                            got.used_n, want.used_n));
            end
         end
         if (req_mon.valid && req_mon.ready)
            answers_due.push_back(predict_answer(req_mon.action, req_mon.key_value,
                                                 req_mon.slot_index));
      end
      due_count <= answers_due.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the keyed slot table: a directed run through duplicates,
// holes, queries and a full table, then random phases of inserts, removes
// and queries over several slot counts, with random gaps on the request
// side and random stalls on the response side. The scoreboard does the
// checking; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import kst_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
   localparam int POOL_DEPTH   = 80;
   localparam int PHASE_ITEMS  = 93;
   localparam int STALL_LIMIT  = 5000;
   localparam int END_CYCLES   = 80;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [COUNT_W-1:0] csr_write_data;
   bit                 steady;
   int                 fail_count;
   int                 due_count;
   int                 quiet_cycles;
   logic [KEY_W-1:0]   key_pool [POOL_DEPTH];

   kst_req_if req_chan ();
   kst_rsp_if rsp_chan ();

   keyed_slot_table_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   kst_table_scoreboard table_watch (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .fail_count       (fail_count),
      .due_count        (due_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(99) >= 19);
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_word(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key,
                            input logic [INDEX_W-1:0] idx);
      while (!steady && $urandom_range(99) < 19) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.key_value  <= key;
      req_chan.slot_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic settle_table();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [COUNT_W-1:0] limit);
      settle_table();
      csr_write_enable <= 1'b1;
      csr_write_data   <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input int n_items);
      int                  span;
      int                  pick;
      logic [ACTION_W-1:0] act;
      logic [KEY_W-1:0]    key;
      span = $urandom_range(POOL_DEPTH, 3);
      for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = KEY_W'($urandom());
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(99);
         if (pick < 48)      act = ACT_INSERT;
         else if (pick < 73) act = ACT_REMOVE;
         else if (pick < 94) act = ACT_QUERY;
         else                act = ACT_UNKNOWN;
         if ($urandom_range(9) == 0) key = KEY_W'($urandom());
         else                        key = key_pool[$urandom_range(span - 1)];
         send_word(act, key, INDEX_W'($urandom()));
      end
   endtask

   initial begin
      logic [COUNT_W-1:0] phase_limits [10];
      phase_limits = '{7'd1, 7'd64, 7'd0, 7'd2, 7'd127, 7'd13, 7'd64, 7'd33, 7'd5, 7'd64};
      reset               = 1'b1;
      steady              = 1'b0;
      quiet_cycles        = 0;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      req_chan.valid      = 1'b0;
      req_chan.action     = ACT_INSERT;
      req_chan.key_value  = '0;
      req_chan.slot_index = '0;
      rsp_chan.ready      = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(ACT_INSERT, 31'h0000_0000, 6'd0);
      send_word(ACT_INSERT, 31'h7FFF_FFFF, 6'd0);
      send_word(ACT_INSERT, 31'h0000_0000, 6'd63);
      send_word(ACT_QUERY,  31'h7FFF_FFFF, 6'd0);
      send_word(ACT_QUERY,  31'h0000_0000, 6'd1);
      send_word(ACT_QUERY,  31'h0000_0000, 6'd2);
      send_word(ACT_QUERY,  31'h0000_0000, 6'd63);
      send_word(ACT_REMOVE, 31'h7FFF_FFFF, 6'd0);
      send_word(ACT_REMOVE, 31'h2AAA_AAAA, 6'd0);
      send_word(ACT_INSERT, 31'h5555_5555, 6'd0);
      send_word(ACT_REMOVE, 31'h0000_0000, 6'd0);
      // hole at slot 0 hides the copy in slot 1
      send_word(ACT_INSERT, 31'h5555_5555, 6'd0);
      send_word(ACT_QUERY,  31'h0000_0000, 6'd1);
      send_word(ACT_UNKNOWN, 31'h7FFF_FFFF, 6'd63);
      send_word(ACT_REMOVE, 31'h5555_5555, 6'd0);
      send_word(ACT_REMOVE, 31'h5555_5555, 6'd0);
      send_word(ACT_REMOVE, 31'h5555_5555, 6'd0);
      write_slot_count(7'd2);
      send_word(ACT_INSERT, 31'h0000_0001, 6'd0);
      send_word(ACT_INSERT, 31'h0000_0002, 6'd0);
      send_word(ACT_INSERT, 31'h0000_0003, 6'd0);
      send_word(ACT_QUERY,  31'h0000_0000, 6'd2);
      send_word(ACT_QUERY,  31'h0000_0000, 6'd63);
      send_word(ACT_QUERY,  31'h0000_0000, 6'd1);

      for (int p = 0; p < 10; p++) begin
         write_slot_count(phase_limits[p]);
         steady <= (p == 6);
         run_phase(PHASE_ITEMS);
      end

      settle_table();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/kst_pkg.sv
src/kst_req_if.sv
src/kst_rsp_if.sv
src/kst_ram.sv
src/kst_ctrl.sv
src/kst_datapath.sv
src/keyed_slot_table_core.sv
tb/kst_table_scoreboard.sv
tb/tb_top.sv
